// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Every user has clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define LSH_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define LSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lsh_pkg.sv =====
package lsh_pkg;

  localparam int unsigned HIST_BINS_DEF  = 100;
  localparam int unsigned HIST_RANGE_DEF = 1000;

  localparam int TIME_W = 48;
  localparam int LAT_W  = 32;
  localparam int SUM_W  = 64;
  localparam int CNT_W  = 32;
  localparam int CFG_W  = 20;
  localparam int RBIN_W = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 20'd1000;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic {
    ACT_RECORD = 1'b0,
    ACT_READ   = 1'b1
  } action_t;

  typedef struct packed {
    action_t          action;
    logic [LAT_W-1:0] lat;
    logic             ovr;
  } lsh_job_t;

endpackage

// ===== rtl/lsh_in_if.sv =====
interface lsh_in_if import lsh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [TIME_W-1:0] expected_time_us;
  logic [TIME_W-1:0] actual_time_us;
  logic [RBIN_W-1:0] read_bin;

  modport source (output valid, action, expected_time_us, actual_time_us, read_bin,
                  input ready);
  modport sink (input valid, action, expected_time_us, actual_time_us, read_bin,
                output ready);
endinterface

// ===== rtl/lsh_out_if.sv =====
interface lsh_out_if import lsh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LAT_W-1:0]  sample_latency;
  logic [LAT_W-1:0]  min_latency;
  logic [LAT_W-1:0]  max_latency;
  logic [SUM_W-1:0]  latency_sum;
  logic [CNT_W-1:0]  sample_count;
  logic [CNT_W-1:0]  overrun_count;
  logic [RBIN_W-1:0] bin_number;
  logic [CNT_W-1:0]  bin_count;

  modport source (output valid, sample_latency, min_latency, max_latency, latency_sum,
                  sample_count, overrun_count, bin_number, bin_count,
                  input ready);
  modport sink (input valid, sample_latency, min_latency, max_latency, latency_sum,
                sample_count, overrun_count, bin_number, bin_count,
                output ready);
endinterface

// ===== rtl/latency_stats_histogram_top.sv =====
// Wakeup-latency monitor with histogram. A record transaction gives one result with
// the clamped latency, the updated statistics and the new count of its bin; a read
// transaction returns one bin's count without changing anything. The block sustains
// one transaction per cycle while results are taken, limited by the read-modify-write
// of the bin memory, which forwards its last write so back-to-back hits on one bin
// cost nothing. A transaction passes through the front (latency, bin scaling multiply,
// reciprocal multiply), the queue, the bin read and the result register. After reset
// the input is not ready while the bin memory is swept to zero; configuration writes
// are taken during that time.
module latency_stats_histogram_top import lsh_pkg::*; #(
  parameter int unsigned HIST_BINS     = HIST_BINS_DEF,
  parameter int unsigned HIST_RANGE_US = HIST_RANGE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  lsh_in_if.sink           sample,
  lsh_out_if.source        result,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int BIN_W = $clog2(HIST_BINS);
  localparam int QW    = $bits(lsh_job_t) + BIN_W;

  logic [CFG_W-1:0] interval;
  logic             clearing;
  logic             q_full;
  logic             q_valid;
  logic             push;
  logic             pop;
  lsh_job_t         push_job;
  logic [BIN_W-1:0] push_bin;
  logic [QW-1:0]    q_head;
  lsh_job_t         q_job;
  logic [BIN_W-1:0] q_bin;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= CFG_RESET;
    end else if (cfg_we) begin
      interval <= cfg_wdata;
    end
  end

  lsh_front #(
    .HIST_BINS     (HIST_BINS),
    .HIST_RANGE_US (HIST_RANGE_US)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .interval (interval),
    .clearing (clearing),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job),
    .push_bin (push_bin)
  );

  lsh_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    ({push_job, push_bin}),
    .pop      (pop),
    .head     (q_head),
    .full     (q_full),
    .nonempty (q_valid)
  );

  assign {q_job, q_bin} = q_head;

  lsh_back #(
    .HIST_BINS (HIST_BINS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .q_bin    (q_bin),
    .pop      (pop),
    .clearing (clearing),
    .result   (result)
  );

endmodule

// ===== rtl/lsh_ram.sv =====
module lsh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lsh_front.sv =====
module lsh_front import lsh_pkg::*; #(
  parameter int unsigned HIST_BINS     = HIST_BINS_DEF,
  parameter int unsigned HIST_RANGE_US = HIST_RANGE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  lsh_in_if.sink                       sample,
  input  logic [CFG_W-1:0]             interval,
  input  logic                         clearing,
  input  logic                         q_full,
  output logic                         push,
  output lsh_job_t                     push_job,
  output logic [$clog2(HIST_BINS)-1:0] push_bin
);

  localparam int BIN_W = $clog2(HIST_BINS);
  localparam longint unsigned THRESH =
    ((longint'(HIST_BINS) - 1) * longint'(HIST_RANGE_US) + longint'(HIST_BINS) - 1)
    / longint'(HIST_BINS);
  localparam int LW = $clog2(HIST_RANGE_US);
  localparam int XW = $clog2(longint'(HIST_RANGE_US) * longint'(HIST_BINS));
  localparam int SH = XW + LW;
  localparam int MW = XW + 1;
  localparam int PW = XW + MW;
  localparam longint unsigned MAGIC =
    ((longint'(1) << SH) + longint'(HIST_RANGE_US) - 1) / longint'(HIST_RANGE_US);

  logic                  en;
  logic [TIME_W:0]       diff;
  logic [LAT_W-1:0]      lat_in;
  logic [BIN_W-1:0]      rbin_in;

  logic                  v1;
  lsh_job_t              job1;
  logic [BIN_W-1:0]      bin1;

  logic                  v2;
  lsh_job_t              job2;
  logic                  hi2;
  logic [XW-1:0]         x2;
  logic [BIN_W-1:0]      bin2;

  logic                  v3;
  lsh_job_t              job3;
  logic                  hi3;
  logic [PW-1:0]         prod3;
  logic [BIN_W-1:0]      bin3;

  assign en           = !(v3 && q_full);
  assign sample.ready = en && !clearing;

  always_comb begin
    diff = {1'b0, sample.actual_time_us} - {1'b0, sample.expected_time_us};
    if (action_t'(sample.action) == ACT_READ || diff[TIME_W]) begin
      lat_in = '0;
    end else if (|diff[TIME_W-1:LAT_W]) begin
      lat_in = '1;
    end else begin
      lat_in = diff[LAT_W-1:0];
    end
    if (32'(sample.read_bin) >= 32'(HIST_BINS)) begin
      rbin_in = BIN_W'(HIST_BINS - 1);
    end else begin
      rbin_in = BIN_W'(sample.read_bin);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= sample.valid && sample.ready;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      job1.action <= action_t'(sample.action);
      job1.lat    <= lat_in;
      job1.ovr    <= 1'b0;
      bin1        <= rbin_in;

      job2.action <= job1.action;
      job2.lat    <= job1.lat;
      job2.ovr    <= job1.action == ACT_RECORD && job1.lat > LAT_W'({interval, 1'b0});
      hi2         <= job1.lat >= LAT_W'(THRESH);
      x2          <= XW'(job1.lat[LW-1:0]) * XW'(HIST_BINS);
      bin2        <= bin1;

      job3        <= job2;
      hi3         <= hi2;
      prod3       <= PW'(x2) * PW'(MW'(MAGIC));
      bin3        <= bin2;
    end
  end

  assign push     = v3 && !q_full;
  assign push_job = job3;

  always_comb begin
    if (job3.action == ACT_READ) begin
      push_bin = bin3;
    end else if (hi3) begin
      push_bin = BIN_W'(HIST_BINS - 1);
    end else begin
      push_bin = prod3[SH +: BIN_W];
    end
  end

endmodule

// ===== rtl/lsh_queue.sv =====
`include "assert_macros.svh"

module lsh_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             nonempty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(DEPTH);
  assign nonempty = count != '0;
  assign head     = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  `LSH_ASSERT(q_no_overflow, !(push && full), "Queue written while full.")
  `LSH_ASSERT(q_no_underflow, !(pop && !nonempty), "Queue read while empty.")

endmodule

// ===== rtl/lsh_back.sv =====
`include "assert_macros.svh"

module lsh_back import lsh_pkg::*; #(
  parameter int unsigned HIST_BINS = HIST_BINS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  lsh_job_t                     q_job,
  input  logic [$clog2(HIST_BINS)-1:0] q_bin,
  output logic                         pop,
  output logic                         clearing,
  lsh_out_if.source                    result
);

  localparam int BIN_W = $clog2(HIST_BINS);

  logic               clr_active;
  logic [BIN_W-1:0]   clr_addr;

  logic               eb;
  logic               advance;

  logic               v2;
  lsh_job_t           job2;
  logic [BIN_W-1:0]   bin2;

  logic [CNT_W-1:0]   rdata;
  logic               lw_valid;
  logic [BIN_W-1:0]   lw_addr;
  logic [CNT_W-1:0]   lw_data;

  logic [CNT_W-1:0]   cur;
  logic [CNT_W-1:0]   bumped;
  logic               bin_we;

  logic               ram_we;
  logic [BIN_W-1:0]   ram_waddr;
  logic [CNT_W-1:0]   ram_wdata;

  logic [LAT_W-1:0]   min_reg, min_next;
  logic [LAT_W-1:0]   max_reg, max_next;
  logic [SUM_W-1:0]   sum_reg, sum_next;
  logic [CNT_W-1:0]   count_reg, count_next;
  logic [CNT_W-1:0]   overrun_reg, overrun_next;
  logic [SUM_W:0]     sum_wide;

  logic               res_valid;
  logic [LAT_W-1:0]   res_lat;
  logic [LAT_W-1:0]   res_min;
  logic [LAT_W-1:0]   res_max;
  logic [SUM_W-1:0]   res_sum;
  logic [CNT_W-1:0]   res_count;
  logic [CNT_W-1:0]   res_overrun;
  logic [RBIN_W-1:0]  res_bin;
  logic [CNT_W-1:0]   res_bin_count;

  assign clearing = clr_active;
  assign eb       = !res_valid || result.ready;
  assign advance  = eb && !clr_active;
  assign pop      = advance && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == BIN_W'(HIST_BINS - 1)) begin
        clr_active <= 1'b0;
      end
    end
  end

  always_comb begin
    cur    = (lw_valid && lw_addr == bin2) ? lw_data : rdata;
    bumped = (cur == '1) ? cur : cur + 1'b1;
    bin_we = advance && v2 && job2.action == ACT_RECORD;
    if (clr_active) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = bin_we;
      ram_waddr = bin2;
      ram_wdata = bumped;
    end
  end

  lsh_ram #(
    .WIDTH (CNT_W),
    .DEPTH (HIST_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (advance),
    .raddr (q_bin),
    .rdata (rdata)
  );

  always_comb begin
    min_next     = min_reg;
    max_next     = max_reg;
    sum_next     = sum_reg;
    count_next   = count_reg;
    overrun_next = overrun_reg;
    sum_wide     = {1'b0, sum_reg} + (SUM_W + 1)'(job2.lat);
    if (job2.action == ACT_RECORD) begin
      if (job2.lat < min_reg) begin
        min_next = job2.lat;
      end
      if (job2.lat > max_reg) begin
        max_next = job2.lat;
      end
      sum_next   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;
      if (job2.ovr && overrun_reg != '1) begin
        overrun_next = overrun_reg + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2          <= 1'b0;
      lw_valid    <= 1'b0;
      res_valid   <= 1'b0;
      min_reg     <= '1;
      max_reg     <= '0;
      sum_reg     <= '0;
      count_reg   <= '0;
      overrun_reg <= '0;
    end else begin
      if (advance) begin
        v2 <= q_valid;
      end
      if (clr_active) begin
        lw_valid <= 1'b0;
      end else if (bin_we) begin
        lw_valid <= 1'b1;
      end
      if (eb) begin
        res_valid <= advance && v2;
      end
      if (advance && v2) begin
        min_reg     <= min_next;
        max_reg     <= max_next;
        sum_reg     <= sum_next;
        count_reg   <= count_next;
        overrun_reg <= overrun_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job2 <= q_job;
      bin2 <= q_bin;
    end
    if (bin_we) begin
      lw_addr <= bin2;
      lw_data <= bumped;
    end
    if (advance && v2) begin
      res_lat       <= job2.lat;
      res_min       <= min_next;
      res_max       <= max_next;
      res_sum       <= sum_next;
      res_count     <= count_next;
      res_overrun   <= overrun_next;
      res_bin       <= RBIN_W'(bin2);
      res_bin_count <= (job2.action == ACT_RECORD) ? bumped : cur;
    end
  end

  assign result.valid          = res_valid;
  assign result.sample_latency = res_lat;
  assign result.min_latency    = res_min;
  assign result.max_latency    = res_max;
  assign result.latency_sum    = res_sum;
  assign result.sample_count   = res_count;
  assign result.overrun_count  = res_overrun;
  assign result.bin_number     = res_bin;
  assign result.bin_count      = res_bin_count;

  `LSH_ASSERT(bk_no_pop_clear, !(clr_active && pop), "Item taken during bin clear.")
  `LSH_ASSERT_NEXT(bk_result_load, advance && v2, res_valid, "Finished item lost.")

endmodule
